@@ rtl/led_chaser_pwm_dimmer_defines.svh @@
// Assertion helpers shared by the LED chaser RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef LED_CHASER_PWM_DIMMER_DEFINES_SVH
`define LED_CHASER_PWM_DIMMER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define LCPD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LCPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define LCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lcpd_pkg.sv @@
package lcpd_pkg;

    // Field and register widths.
    localparam int CMD_W       = 3;
    localparam int ADC_W       = 8;
    localparam int LED_COUNT   = 8;
    localparam int LED_POS_W   = $clog2(LED_COUNT);
    localparam int PAIR_POS_W  = 2;
    localparam int MODE_W      = 3;
    localparam int LEVEL_W     = 3;
    localparam int OFF_W       = 7;
    localparam int REG_W       = 12;
    localparam int COUNT_W     = 11;
    localparam int NUM_MODES   = 4;
    localparam int MODE_IDX_W  = 2;
    localparam int CFG_IDX_W   = 2;

    // Commands carried by an input item.
    localparam logic [CMD_W-1:0] CMD_SLOW_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PWM_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BRIGHTNESS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN_TOGGLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MODE1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MODE2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MODE3 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MODE4 = 2'd3;
    localparam logic [REG_W-1:0]     INTERVAL_RESET     = 12'd400;

    // Pattern modes as seen on the result.
    localparam logic [MODE_W-1:0] MODE_LEFT      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PAIR_IN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAIR_OUT  = 3'd4;

    localparam logic [LED_COUNT-1:0] LEDS_OFF = 8'hFF;
    localparam logic [LED_POS_W-1:0] LED_LAST = LED_POS_W'(LED_COUNT - 1);

    // Brightness thresholds and the off-times they select.
    localparam logic [ADC_W-1:0]   ADC_LIMIT_DARK  = 8'd60;
    localparam logic [ADC_W-1:0]   ADC_LIMIT_DIM   = 8'd130;
    localparam logic [ADC_W-1:0]   ADC_LIMIT_MID   = 8'd195;
    localparam logic [OFF_W-1:0]   OFF_TIME_DARK   = 7'd90;
    localparam logic [OFF_W-1:0]   OFF_TIME_DIM    = 7'd70;
    localparam logic [OFF_W-1:0]   OFF_TIME_MID    = 7'd30;
    localparam logic [OFF_W-1:0]   OFF_TIME_BRIGHT = 7'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_DARK      = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_DIM       = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MID       = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT    = 3'd4;

    // One result item.
    typedef struct packed {
        logic [LED_COUNT-1:0] led_drive;
        logic [LED_COUNT-1:0] pattern;
        logic [MODE_W-1:0]    mode;
        logic [LEVEL_W-1:0]   brightness_level;
    } result_t;

    // Active-low pair moving from the outer LEDs towards the centre.
    function automatic logic [LED_COUNT-1:0] pair_in_pattern(input logic [PAIR_POS_W-1:0] pos);
        logic [LED_COUNT-1:0] pat;
        case (pos)
            2'd0:    pat = 8'h7E;
            2'd1:    pat = 8'hBD;
            2'd2:    pat = 8'hDB;
            2'd3:    pat = 8'hE7;
            default: pat = LEDS_OFF;
        endcase
        return pat;
    endfunction

    // The outward sequence is the inward one read backwards.
    function automatic logic [LED_COUNT-1:0] pair_out_pattern(input logic [PAIR_POS_W-1:0] pos);
        return pair_in_pattern(~pos);
    endfunction

endpackage

@@ rtl/lcpd_if.sv @@
// Input channel: one command and its light sample per transfer.
interface lcpd_in_if;
    logic                          valid;
    logic                          ready;
    logic [lcpd_pkg::CMD_W-1:0]    cmd;
    logic [lcpd_pkg::ADC_W-1:0]    adc_value;

    modport source (output valid, output cmd, output adc_value, input ready);
    modport sink   (input valid, input cmd, input adc_value, output ready);
endinterface

// Result channel: port value, pattern, mode and brightness per transfer.
interface lcpd_out_if;
    logic                             valid;
    logic                             ready;
    logic [lcpd_pkg::LED_COUNT-1:0]   led_drive;
    logic [lcpd_pkg::LED_COUNT-1:0]   pattern;
    logic [lcpd_pkg::MODE_W-1:0]      mode;
    logic [lcpd_pkg::LEVEL_W-1:0]     brightness_level;

    modport source (output valid, output led_drive, output pattern, output mode,
                    output brightness_level, input ready);
    modport sink   (input valid, input led_drive, input pattern, input mode,
                    input brightness_level, output ready);
endinterface

@@ rtl/lcpd_out_buf.sv @@
`include "led_chaser_pwm_dimmer_defines.svh"

module lcpd_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  lcpd_pkg::result_t   push_data,
    lcpd_out_if.source          out_ch
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    lcpd_pkg::result_t out_data_reg;
    lcpd_pkg::result_t out_data_next;
    lcpd_pkg::result_t skid_data_reg;
    lcpd_pkg::result_t skid_data_next;
    logic              push_fire;
    logic              pop_fire;

    // A new result is taken as long as the skid entry is free.
    assign push_ready = !skid_valid_reg;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = out_valid_reg && out_ch.ready;

    // Two-entry queue: the output entry drives the port, the skid entry catches a stall.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_fire)
        begin
            if (!out_valid_reg || pop_fire)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Occupancy flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.led_drive        = out_data_reg.led_drive;
    assign out_ch.pattern          = out_data_reg.pattern;
    assign out_ch.mode             = out_data_reg.mode;
    assign out_ch.brightness_level = out_data_reg.brightness_level;

    // The skid entry is only ever filled behind a waiting output entry.
    `LCPD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output entry")
    // Draining a full queue moves the skid entry forward.
    `LCPD_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_ch.ready, out_valid_reg && !skid_valid_reg, "full queue did not drain")
    // A result into an empty queue goes straight to the port.
    `LCPD_ASSERT_NEXT(a_empty_fill, push_fire && !out_valid_reg, out_valid_reg && !skid_valid_reg, "empty queue fill went astray")

endmodule

@@ rtl/led_chaser_pwm_dimmer.sv @@
// Channel   Direction  Payload                                      Transfer
// in_ch     sink       cmd[2:0], adc_value[7:0]                     valid && ready
// out_ch    source     led_drive, pattern[7:0], mode, brightness    valid && ready
// cfg       write      cfg_index[1:0], cfg_wdata[11:0]              cfg_we
//
// One input item is taken in every cycle while in_ch.ready is high; its result is
// set by the combinational state update path and registered in the output entry
// that drives out_ch, or in the skid entry while the output entry is held.
// So in_ch stays ready while one entry is held; in_ch.ready falls only while both are.
// Reset is asynchronous and ready for items at once: intervals read 400, mode 1, stopped.
`include "led_chaser_pwm_dimmer_defines.svh"

module led_chaser_pwm_dimmer
#(
    parameter int PWM_STEPS = 101
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    lcpd_in_if.sink                          in_ch,
    lcpd_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [lcpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcpd_pkg::REG_W-1:0]       cfg_wdata
);

    localparam int PWM_W = $clog2(PWM_STEPS);
    localparam int CMP_W = (PWM_W > lcpd_pkg::OFF_W) ? PWM_W : lcpd_pkg::OFF_W;
    localparam logic [PWM_W-1:0] PWM_LAST = PWM_W'(PWM_STEPS - 1);

    logic [lcpd_pkg::REG_W-1:0]      interval_reg [lcpd_pkg::NUM_MODES];
    logic [lcpd_pkg::COUNT_W-1:0]    count_reg    [lcpd_pkg::NUM_MODES];
    logic [lcpd_pkg::COUNT_W-1:0]    count_next   [lcpd_pkg::NUM_MODES];
    logic [lcpd_pkg::NUM_MODES-1:0]  pending_reg;
    logic [lcpd_pkg::NUM_MODES-1:0]  pending_next;
    logic [lcpd_pkg::MODE_W-1:0]     mode_reg;
    logic [lcpd_pkg::MODE_W-1:0]     mode_next;
    logic                            running_reg;
    logic                            running_next;
    logic [lcpd_pkg::LED_POS_W-1:0]  left_pos_reg;
    logic [lcpd_pkg::LED_POS_W-1:0]  left_pos_next;
    logic [lcpd_pkg::LED_POS_W-1:0]  right_pos_reg;
    logic [lcpd_pkg::LED_POS_W-1:0]  right_pos_next;
    logic [lcpd_pkg::PAIR_POS_W-1:0] in_pos_reg;
    logic [lcpd_pkg::PAIR_POS_W-1:0] in_pos_next;
    logic [lcpd_pkg::PAIR_POS_W-1:0] out_pos_reg;
    logic [lcpd_pkg::PAIR_POS_W-1:0] out_pos_next;
    logic [lcpd_pkg::OFF_W-1:0]      off_time_reg;
    logic [lcpd_pkg::OFF_W-1:0]      off_time_next;
    logic [lcpd_pkg::LED_COUNT-1:0]  shown_reg;
    logic [lcpd_pkg::LED_COUNT-1:0]  shown_next;
    logic [PWM_W-1:0]                pwm_reg;
    logic [PWM_W-1:0]                pwm_next;
    logic [lcpd_pkg::LEVEL_W-1:0]    level_reg;
    logic [lcpd_pkg::LEVEL_W-1:0]    level_next;

    logic                            in_fire;
    logic                            push_ready;
    logic [lcpd_pkg::MODE_IDX_W-1:0] mode_idx;
    logic [lcpd_pkg::COUNT_W-1:0]    threshold;
    logic [lcpd_pkg::COUNT_W:0]      tick_sum;
    lcpd_pkg::result_t               result;

    assign in_ch.ready = push_ready;
    assign in_fire     = in_ch.valid && push_ready;

    // Slow tick compare for the running mode: half its interval.
    assign mode_idx  = lcpd_pkg::MODE_IDX_W'(mode_reg - 3'd1);
    assign threshold = interval_reg[mode_idx][lcpd_pkg::REG_W-1:1];
    assign tick_sum  = {1'b0, count_reg[mode_idx]} + 12'd1;

    // Apply the command, then, while running, take every pending step in mode order.
    always_comb
    begin
        count_next     = count_reg;
        pending_next   = pending_reg;
        mode_next      = mode_reg;
        running_next   = running_reg;
        left_pos_next  = left_pos_reg;
        right_pos_next = right_pos_reg;
        in_pos_next    = in_pos_reg;
        out_pos_next   = out_pos_reg;
        off_time_next  = off_time_reg;
        shown_next     = shown_reg;
        pwm_next       = pwm_reg;
        level_next     = level_reg;
        if (in_fire)
        begin
            case (in_ch.cmd)
                lcpd_pkg::CMD_SLOW_TICK:
                begin
                    if (tick_sum >= {1'b0, threshold})
                    begin
                        count_next[mode_idx]   = '0;
                        pending_next[mode_idx] = 1'b1;
                    end
                    else
                    begin
                        count_next[mode_idx] = tick_sum[lcpd_pkg::COUNT_W-1:0];
                    end
                end
                lcpd_pkg::CMD_PWM_TICK:
                begin
                    pwm_next = (pwm_reg == PWM_LAST) ? '0 : pwm_reg + 1'b1;
                end
                lcpd_pkg::CMD_BRIGHTNESS:
                begin
                    if (in_ch.adc_value < lcpd_pkg::ADC_LIMIT_DARK)
                    begin
                        off_time_next = lcpd_pkg::OFF_TIME_DARK;
                        level_next    = lcpd_pkg::LEVEL_DARK;
                    end
                    else if (in_ch.adc_value < lcpd_pkg::ADC_LIMIT_DIM)
                    begin
                        off_time_next = lcpd_pkg::OFF_TIME_DIM;
                        level_next    = lcpd_pkg::LEVEL_DIM;
                    end
                    else if (in_ch.adc_value < lcpd_pkg::ADC_LIMIT_MID)
                    begin
                        off_time_next = lcpd_pkg::OFF_TIME_MID;
                        level_next    = lcpd_pkg::LEVEL_MID;
                    end
                    else
                    begin
                        off_time_next = lcpd_pkg::OFF_TIME_BRIGHT;
                        level_next    = lcpd_pkg::LEVEL_BRIGHT;
                    end
                end
                lcpd_pkg::CMD_RUN_TOGGLE:
                begin
                    running_next = !running_reg;
                end
                lcpd_pkg::CMD_RESTART:
                begin
                    mode_next = lcpd_pkg::MODE_LEFT;
                end
                default:
                begin
                end
            endcase

            // Each pending step touches only its own position; the last one wins the pattern.
            if (running_next)
            begin
                if (pending_next[0])
                begin
                    pending_next[0] = 1'b0;
                    shown_next = ~(lcpd_pkg::LED_COUNT'(1) << left_pos_reg);
                    if (left_pos_reg == lcpd_pkg::LED_LAST)
                    begin
                        left_pos_next = '0;
                        mode_next     = lcpd_pkg::MODE_RIGHT;
                    end
                    else
                    begin
                        left_pos_next = left_pos_reg + 1'b1;
                    end
                end
                if (pending_next[1])
                begin
                    pending_next[1] = 1'b0;
                    shown_next = ~({1'b1, {(lcpd_pkg::LED_COUNT - 1){1'b0}}} >> right_pos_reg);
                    if (right_pos_reg == lcpd_pkg::LED_LAST)
                    begin
                        right_pos_next = '0;
                        mode_next      = lcpd_pkg::MODE_PAIR_IN;
                    end
                    else
                    begin
                        right_pos_next = right_pos_reg + 1'b1;
                    end
                end
                if (pending_next[2])
                begin
                    pending_next[2] = 1'b0;
                    shown_next  = lcpd_pkg::pair_in_pattern(in_pos_reg);
                    in_pos_next = in_pos_reg + 1'b1;
                    if (in_pos_next == '0)
                    begin
                        mode_next = lcpd_pkg::MODE_PAIR_OUT;
                    end
                end
                if (pending_next[3])
                begin
                    pending_next[3] = 1'b0;
                    shown_next   = lcpd_pkg::pair_out_pattern(out_pos_reg);
                    out_pos_next = out_pos_reg + 1'b1;
                    if (out_pos_next == '0)
                    begin
                        mode_next = lcpd_pkg::MODE_LEFT;
                    end
                end
            end
        end
    end

    // Result of the item, taken from the updated state.
    always_comb
    begin
        if (running_next && (CMP_W'(pwm_next) >= CMP_W'(off_time_next)))
        begin
            result.led_drive = shown_next;
        end
        else
        begin
            result.led_drive = lcpd_pkg::LEDS_OFF;
        end
        result.pattern          = shown_next;
        result.mode             = mode_next;
        result.brightness_level = level_next;
    end

    // Interval registers, which the user writes only while idle; the block does not check it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcpd_pkg::NUM_MODES; i++)
            begin
                interval_reg[i] <= lcpd_pkg::INTERVAL_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcpd_pkg::REG_INTERVAL_MODE1: interval_reg[0] <= cfg_wdata;
                lcpd_pkg::REG_INTERVAL_MODE2: interval_reg[1] <= cfg_wdata;
                lcpd_pkg::REG_INTERVAL_MODE3: interval_reg[2] <= cfg_wdata;
                lcpd_pkg::REG_INTERVAL_MODE4: interval_reg[3] <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Chaser and dimmer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcpd_pkg::NUM_MODES; i++)
            begin
                count_reg[i] <= '0;
            end
            pending_reg   <= '0;
            mode_reg      <= lcpd_pkg::MODE_LEFT;
            running_reg   <= 1'b0;
            left_pos_reg  <= '0;
            right_pos_reg <= '0;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            off_time_reg  <= '0;
            shown_reg     <= lcpd_pkg::LEDS_OFF;
            pwm_reg       <= '0;
            level_reg     <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            mode_reg      <= mode_next;
            running_reg   <= running_next;
            left_pos_reg  <= left_pos_next;
            right_pos_reg <= right_pos_next;
            in_pos_reg    <= in_pos_next;
            out_pos_reg   <= out_pos_next;
            off_time_reg  <= off_time_next;
            shown_reg     <= shown_next;
            pwm_reg       <= pwm_next;
            level_reg     <= level_next;
        end
    end

    // Result queue towards the output channel.
    lcpd_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_fire),
        .push_ready (push_ready),
        .push_data  (result),
        .out_ch     (out_ch)
    );

    // While running, every latched step is taken by the item that latched it.
    `LCPD_ASSERT_SAME(a_running_no_pending, running_reg, pending_reg == '0, "step left pending while running")
    // While stopped, latched steps are kept.
    `LCPD_ASSERT_NEXT(a_stopped_keeps, !running_next, (pending_reg & $past(pending_reg)) == $past(pending_reg), "pending step lost while stopped")
    // The mode stays within the four patterns.
    `LCPD_ASSERT_ALWAYS(a_mode_range, mode_reg != 3'd0 && mode_reg <= lcpd_pkg::MODE_PAIR_OUT, "mode out of range")
    // The PWM counter wraps before the step count.
    `LCPD_ASSERT_ALWAYS(a_pwm_range, pwm_reg <= PWM_LAST, "PWM counter past its last step")

endmodule

@@ tb/lcpd_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the register write port. It keeps its own copy of
// the chaser and dimmer state, works out the frame that each input transfer
// should produce and compares every result transfer with the oldest one due.
module lcpd_checker
#(
    parameter int PWM_STEPS = 101
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    lcpd_in_if                             in_mon,
    lcpd_out_if                            out_mon,
    input  logic                           cfg_we,
    input  logic [lcpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcpd_pkg::REG_W-1:0]     cfg_wdata,
    output int                             fail_count,
    output int                             outstanding
);

    // Active-low pair patterns, indexed by the pair position.
    localparam logic [lcpd_pkg::LED_COUNT-1:0] INWARD_PAIRS [4]  =
        '{8'h7E, 8'hBD, 8'hDB, 8'hE7};
    localparam logic [lcpd_pkg::LED_COUNT-1:0] OUTWARD_PAIRS [4] =
        '{8'hE7, 8'hDB, 8'hBD, 8'h7E};

    // Shadow of the block's registers and state.
    logic [lcpd_pkg::REG_W-1:0]      interval_ms [lcpd_pkg::NUM_MODES];
    logic [lcpd_pkg::REG_W-1:0]      tick_count [lcpd_pkg::NUM_MODES];
    logic                            step_due [lcpd_pkg::NUM_MODES];
    logic                            running;
    logic [lcpd_pkg::MODE_W-1:0]     cur_mode;
    logic [lcpd_pkg::LED_POS_W-1:0]  left_pos;
    logic [lcpd_pkg::LED_POS_W-1:0]  right_pos;
    logic [lcpd_pkg::PAIR_POS_W-1:0] inward_pos;
    logic [lcpd_pkg::PAIR_POS_W-1:0] outward_pos;
    logic [lcpd_pkg::OFF_W-1:0]      off_time;
    logic [lcpd_pkg::LED_COUNT-1:0]  shown;
    int                              pwm_phase;
    logic [lcpd_pkg::LEVEL_W-1:0]    bright_level;

    lcpd_pkg::result_t led_frames_due[$];
    int                mismatches;

    // Show the next step of one mode's pattern; the last step hands over to
    // the next mode, and the outward pairs wrap round to the left shift.
    task step_pattern(input int m);
        case (m)
            0:
            begin
                shown = ~(8'h01 << left_pos);
                if (left_pos == lcpd_pkg::LED_LAST)
                begin
                    left_pos = '0;
                    cur_mode = lcpd_pkg::MODE_RIGHT;
                end
                else
                    left_pos = left_pos + 1'b1;
            end
            1:
            begin
                shown = ~(8'h80 >> right_pos);
                if (right_pos == lcpd_pkg::LED_LAST)
                begin
                    right_pos = '0;
                    cur_mode  = lcpd_pkg::MODE_PAIR_IN;
                end
                else
                    right_pos = right_pos + 1'b1;
            end
            2:
            begin
                shown      = INWARD_PAIRS[inward_pos];
                inward_pos = inward_pos + 1'b1;
                if (inward_pos == '0)
                    cur_mode = lcpd_pkg::MODE_PAIR_OUT;
            end
            default:
            begin
                shown       = OUTWARD_PAIRS[outward_pos];
                outward_pos = outward_pos + 1'b1;
                if (outward_pos == '0)
                    cur_mode = lcpd_pkg::MODE_LEFT;
            end
        endcase
    endtask

    // Apply one command to the shadow state and give the frame it leads to.
    task chase_and_dim(input logic [lcpd_pkg::CMD_W-1:0] cmd,
                       input logic [lcpd_pkg::ADC_W-1:0] adc,
                       output lcpd_pkg::result_t frame);
        logic [lcpd_pkg::MODE_IDX_W-1:0] idx;
        case (cmd)
            lcpd_pkg::CMD_SLOW_TICK:
            begin
                idx = lcpd_pkg::MODE_IDX_W'(cur_mode - 1'b1);
                tick_count[idx] = tick_count[idx] + 1'b1;
                if (tick_count[idx] >= (interval_ms[idx] >> 1))
                begin
                    tick_count[idx] = '0;
                    step_due[idx]   = 1'b1;
                end
            end
            lcpd_pkg::CMD_PWM_TICK:
                pwm_phase = (pwm_phase + 1) % PWM_STEPS;
            lcpd_pkg::CMD_BRIGHTNESS:
            begin
                if (adc < lcpd_pkg::ADC_LIMIT_DARK)
                begin
                    off_time     = lcpd_pkg::OFF_TIME_DARK;
                    bright_level = lcpd_pkg::LEVEL_DARK;
                end
                else if (adc < lcpd_pkg::ADC_LIMIT_DIM)
                begin
                    off_time     = lcpd_pkg::OFF_TIME_DIM;
                    bright_level = lcpd_pkg::LEVEL_DIM;
                end
                else if (adc < lcpd_pkg::ADC_LIMIT_MID)
                begin
                    off_time     = lcpd_pkg::OFF_TIME_MID;
                    bright_level = lcpd_pkg::LEVEL_MID;
                end
                else
                begin
                    off_time     = lcpd_pkg::OFF_TIME_BRIGHT;
                    bright_level = lcpd_pkg::LEVEL_BRIGHT;
                end
            end
            lcpd_pkg::CMD_RUN_TOGGLE:
                running = !running;
            lcpd_pkg::CMD_RESTART:
                cur_mode = lcpd_pkg::MODE_LEFT;
            default:
                ;
        endcase

        // Pending steps are only taken while running, lowest mode first.
        if (running)
        begin
            for (int m = 0; m < lcpd_pkg::NUM_MODES; m++)
            begin
                if (step_due[m])
                begin
                    step_due[m] = 1'b0;
                    step_pattern(m);
                end
            end
        end

        frame.led_drive        = (running && pwm_phase >= int'(off_time)) ? shown
                                                                          : lcpd_pkg::LEDS_OFF;
        frame.pattern          = shown;
        frame.mode             = cur_mode;
        frame.brightness_level = bright_level;
    endtask

    task check_field(input string name, input logic [lcpd_pkg::LED_COUNT-1:0] want_v,
                     input logic [lcpd_pkg::LED_COUNT-1:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Results are compared before the new input is predicted, since a result
    // never leaves in the same cycle as the transfer that caused it.
    always @(posedge clk or negedge rst_n)
    begin : watch
        lcpd_pkg::result_t want;
        if (!rst_n)
        begin
            for (int m = 0; m < lcpd_pkg::NUM_MODES; m++)
            begin
                interval_ms[m] = lcpd_pkg::INTERVAL_RESET;
                tick_count[m]  = '0;
                step_due[m]    = 1'b0;
            end
            running      = 1'b0;
            cur_mode     = lcpd_pkg::MODE_LEFT;
            left_pos     = '0;
            right_pos    = '0;
            inward_pos   = '0;
            outward_pos  = '0;
            off_time     = '0;
            shown        = lcpd_pkg::LEDS_OFF;
            pwm_phase    = 0;
            bright_level = '0;
            led_frames_due.delete();
            mismatches   = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                interval_ms[cfg_index] = cfg_wdata;

            if (out_mon.valid && out_mon.ready)
            begin
                if (led_frames_due.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = led_frames_due.pop_front();
                    check_field("led_drive", want.led_drive, out_mon.led_drive);
                    check_field("pattern", want.pattern, out_mon.pattern);
                    check_field("mode", lcpd_pkg::LED_COUNT'(want.mode),
                                lcpd_pkg::LED_COUNT'(out_mon.mode));
                    check_field("brightness_level",
                                lcpd_pkg::LED_COUNT'(want.brightness_level),
                                lcpd_pkg::LED_COUNT'(out_mon.brightness_level));
                end
            end

            if (in_mon.valid && in_mon.ready)
            begin
                chase_and_dim(in_mon.cmd, in_mon.adc_value, want);
                led_frames_due.push_back(want);
            end

            fail_count  <= mismatches;
            outstanding <= led_frames_due.size();
        end
    end

endmodule

@@ tb/tb_led_chaser_pwm_dimmer.sv @@
`timescale 1ns / 100ps

module tb_led_chaser_pwm_dimmer;

    localparam int PWM_STEPS       = 101;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int QUIET_LIMIT     = 2000;

    // First of the three command codes that the block ignores.
    localparam logic [lcpd_pkg::CMD_W-1:0] CMD_SPARE = lcpd_pkg::CMD_RESTART + 3'd1;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lcpd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lcpd_pkg::REG_W-1:0]     cfg_wdata;
    int                             fail_count;
    int                             outstanding;
    int                             src_idle_pct;
    int                             sink_idle_pct;
    int                             quiet_cycles;

    lcpd_in_if  in_ch ();
    lcpd_out_if out_ch ();

    led_chaser_pwm_dimmer #(
        .PWM_STEPS (PWM_STEPS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lcpd_checker #(
        .PWM_STEPS (PWM_STEPS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // End the run if nothing has been transferred for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one command, with a random gap first, and hold it until the transfer.
    task send_item(input logic [lcpd_pkg::CMD_W-1:0] cmd, input logic [lcpd_pkg::ADC_W-1:0] adc);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.adc_value <= adc;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every expected frame has come back.
    task wait_drained;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task write_intervals(input logic [lcpd_pkg::REG_W-1:0] m1,
                         input logic [lcpd_pkg::REG_W-1:0] m2,
                         input logic [lcpd_pkg::REG_W-1:0] m3,
                         input logic [lcpd_pkg::REG_W-1:0] m4);
        cfg_we    <= 1'b1;
        cfg_index <= lcpd_pkg::REG_INTERVAL_MODE1;
        cfg_wdata <= m1;
        @(posedge clk);
        cfg_index <= lcpd_pkg::REG_INTERVAL_MODE2;
        cfg_wdata <= m2;
        @(posedge clk);
        cfg_index <= lcpd_pkg::REG_INTERVAL_MODE3;
        cfg_wdata <= m3;
        @(posedge clk);
        cfg_index <= lcpd_pkg::REG_INTERVAL_MODE4;
        cfg_wdata <= m4;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                         pick;
        logic [lcpd_pkg::CMD_W-1:0] cmd;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = '0;
        in_ch.adc_value = '0;
        out_ch.ready    = 1'b0;
        quiet_cycles    = 0;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: mode 1 steps on every tick, mode 2 likewise, mode 3
        // needs two ticks and mode 4 has the longest interval.
        write_intervals(12'd0, 12'd1, 12'd4, 12'd2550);

        // Ignored commands still give a frame.
        for (int k = 0; k < 3; k++)
            send_item(CMD_SPARE + lcpd_pkg::CMD_W'(k), 8'hFF);

        // Both sides of every brightness threshold and the ADC extremes.
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd0);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd59);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd60);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd129);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd130);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd194);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd195);
        send_item(lcpd_pkg::CMD_BRIGHTNESS, 8'd255);

        // A step latched while stopped is kept and taken once running.
        send_item(lcpd_pkg::CMD_SLOW_TICK, 8'h00);
        send_item(lcpd_pkg::CMD_SLOW_TICK, 8'hFF);
        send_item(lcpd_pkg::CMD_PWM_TICK, 8'h00);
        send_item(lcpd_pkg::CMD_RUN_TOGGLE, 8'h00);

        // Walk the left shift to its end so that the right shift takes over.
        for (int k = 0; k < 8; k++)
            send_item(lcpd_pkg::CMD_SLOW_TICK, 8'(k));

        // Restart keeps positions; stop, latch a step, then run again.
        send_item(lcpd_pkg::CMD_RESTART, 8'h55);
        send_item(lcpd_pkg::CMD_RUN_TOGGLE, 8'hAA);
        send_item(lcpd_pkg::CMD_SLOW_TICK, 8'h00);
        send_item(lcpd_pkg::CMD_RUN_TOGGLE, 8'h00);
        wait_drained();

        // Random part: short intervals mostly, so the chaser cycles through
        // its modes; the idling pattern changes every two phases.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    src_idle_pct  = 38;
                    sink_idle_pct = 85;
                end
                1:
                begin
                    src_idle_pct  = 85;
                    sink_idle_pct = 38;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            case (phase)
                0:       write_intervals(12'd4, 12'd6, 12'd2, 12'd8);
                1:       write_intervals(12'd2550, 12'd3, 12'd0, 12'd1);
                2:       write_intervals(12'd10, 12'd12, 12'd5, 12'd7);
                3:       write_intervals(12'd0, 12'd0, 12'd0, 12'd0);
                4:       write_intervals(12'd1, 12'd2550, 12'd20, 12'd2);
                default: write_intervals(12'($urandom_range(0, 24)), 12'($urandom_range(0, 24)),
                                         12'($urandom_range(0, 24)), 12'($urandom_range(0, 24)));
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    cmd = lcpd_pkg::CMD_SLOW_TICK;
                else if (pick < 70)
                    cmd = lcpd_pkg::CMD_PWM_TICK;
                else if (pick < 80)
                    cmd = lcpd_pkg::CMD_BRIGHTNESS;
                else if (pick < 86)
                    cmd = lcpd_pkg::CMD_RUN_TOGGLE;
                else if (pick < 91)
                    cmd = lcpd_pkg::CMD_RESTART;
                else
                    cmd = CMD_SPARE + lcpd_pkg::CMD_W'($urandom_range(0, 2));
                send_item(cmd, 8'($urandom_range(0, 255)));
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
